[rtl/lslf_pkg.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit package
// Shared widths, register indexes, operand selects and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lslf_pkg;

    localparam int IN_W            = 24;
    localparam int OUT_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_FRAC_BITS   = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_MODE = 3'd0,
        CFG_X_SOURCE = 3'd1,
        CFG_X_START  = 3'd2,
        CFG_X_STEP   = 3'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {A_SXX = 2'd0, A_SX = 2'd1, A_SXY = 2'd2} t_asel;
    typedef enum logic [1:0] {B_N = 2'd0, B_SX = 2'd1, B_SY = 2'd2} t_bsel;
    typedef enum logic [1:0] {N_ACC = 2'd0, N_SXY = 2'd1, N_SY = 2'd2} t_nsel;
    typedef enum logic [1:0] {D_REG = 2'd0, D_SXX = 2'd1, D_N = 2'd2} t_dsel;

    typedef struct packed {
        logic  mul_go;
        logic  mul_clr;
        logic  mul_sub;
        t_asel asel;
        t_bsel bsel;
        logic  div_go;
        t_nsel nsel;
        t_dsel dsel;
        logic  div_shift;
        logic  div_to_icpt;
        logic  store_d;
        logic  clr_res;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic fit_mode;
        logic sxx_zero;
        logic n_zero;
        logic acc_zero;
        logic mul_busy;
        logic div_busy;
    } t_status;

endpackage

[rtl/lslf_ctrl.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit controller
// Sequences the products of the normal equations and the divisions after the
// last sample of a set, and presents the result strobe.
// ----------------------------------------------------------------------------
module lslf_ctrl
    import lslf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy,
    output logic    o_valid,
    output logic    [1:0] o_rank
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_CHECK      = 14'b00000000000010,
        S_MUL_D0     = 14'b00000000000100,
        S_MUL_D1     = 14'b00000000001000,
        S_TEST_D     = 14'b00000000010000,
        S_MUL_S0     = 14'b00000000100000,
        S_MUL_S1     = 14'b00000001000000,
        S_DIV_S      = 14'b00000010000000,
        S_MUL_I0     = 14'b00000100000000,
        S_MUL_I1     = 14'b00001000000000,
        S_DIV_I      = 14'b00010000000000,
        S_DIV_SLOPE0 = 14'b00100000000000,
        S_DIV_MEAN   = 14'b01000000000000,
        S_EMIT       = 14'b10000000000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_rank, n_rank;

    always_comb begin
        n_state = r_state;
        n_rank  = r_rank;
        case (r_state)
            S_IDLE: begin
                if (i_accept && i_last) begin
                    n_state = S_CHECK;
                    n_rank  = 2'd0;
                end
            end
            S_CHECK: begin
                if (!i_status.fit_mode) begin
                    if (i_status.sxx_zero) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_DIV_SLOPE0;
                        n_rank  = 2'd1;
                    end
                end else if (i_status.n_zero) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MUL_D0;
                end
            end
            S_MUL_D0: if (!i_status.mul_busy) n_state = S_MUL_D1;
            S_MUL_D1: if (!i_status.mul_busy) n_state = S_TEST_D;
            S_TEST_D: begin
                if (i_status.acc_zero) begin
                    n_state = S_DIV_MEAN;
                    n_rank  = 2'd1;
                end else begin
                    n_state = S_MUL_S0;
                end
            end
            S_MUL_S0: if (!i_status.mul_busy) n_state = S_MUL_S1;
            S_MUL_S1: if (!i_status.mul_busy) n_state = S_DIV_S;
            S_DIV_S:  if (!i_status.div_busy) n_state = S_MUL_I0;
            S_MUL_I0: if (!i_status.mul_busy) n_state = S_MUL_I1;
            S_MUL_I1: if (!i_status.mul_busy) n_state = S_DIV_I;
            S_DIV_I: begin
                if (!i_status.div_busy) begin
                    n_state = S_EMIT;
                    n_rank  = 2'd2;
                end
            end
            S_DIV_SLOPE0: if (!i_status.div_busy) n_state = S_EMIT;
            S_DIV_MEAN:   if (!i_status.div_busy) n_state = S_EMIT;
            S_EMIT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands are issued once, on entry to a state. The set is cleared at the
    // end of the result beat.
    always_comb begin
        o_cmd = '0;
        if (n_state != r_state) begin
            case (n_state)
                S_CHECK: o_cmd.clr_res = 1'b1;
                S_MUL_D0: begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_clr = 1'b1;
                    o_cmd.asel    = A_SXX;
                    o_cmd.bsel    = B_N;
                end
                S_MUL_D1: begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sub = 1'b1;
                    o_cmd.asel    = A_SX;
                    o_cmd.bsel    = B_SX;
                end
                S_TEST_D: o_cmd.store_d = 1'b1;
                S_MUL_S0: begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_clr = 1'b1;
                    o_cmd.asel    = A_SXY;
                    o_cmd.bsel    = B_N;
                end
                S_MUL_S1: begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sub = 1'b1;
                    o_cmd.asel    = A_SX;
                    o_cmd.bsel    = B_SY;
                end
                S_DIV_S: begin
                    o_cmd.div_go = 1'b1;
                    o_cmd.nsel   = N_ACC;
                    o_cmd.dsel   = D_REG;
                end
                S_MUL_I0: begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_clr = 1'b1;
                    o_cmd.asel    = A_SXX;
                    o_cmd.bsel    = B_SY;
                end
                S_MUL_I1: begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sub = 1'b1;
                    o_cmd.bsel    = B_SX;
                    o_cmd.asel    = A_SXY;
                end
                S_DIV_I: begin
                    o_cmd.div_go      = 1'b1;
                    o_cmd.nsel        = N_ACC;
                    o_cmd.dsel        = D_REG;
                    o_cmd.div_shift   = 1'b1;
                    o_cmd.div_to_icpt = 1'b1;
                end
                S_DIV_SLOPE0: begin
                    o_cmd.div_go = 1'b1;
                    o_cmd.nsel   = N_SXY;
                    o_cmd.dsel   = D_SXX;
                end
                S_DIV_MEAN: begin
                    o_cmd.div_go      = 1'b1;
                    o_cmd.nsel        = N_SY;
                    o_cmd.dsel        = D_N;
                    o_cmd.div_shift   = 1'b1;
                    o_cmd.div_to_icpt = 1'b1;
                end
                default: o_cmd = '0;
            endcase
        end
        if (r_state == S_EMIT) o_cmd.emit = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rank  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_rank  <= n_rank;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EMIT);
    assign o_rank  = r_rank;

endmodule

[rtl/lslf_datapath.sv]
// ----------------------------------------------------------------------------
// Least-squares line fit datapath
// Configuration registers, running sums, a shift-add multiply-accumulate unit
// and a restoring divider with rounding and Q16.16 saturation.
// ----------------------------------------------------------------------------
module lslf_datapath
    import lslf_pkg::*;
#(
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [IN_W-1:0]         i_cfg_data,
    input  logic                    i_accept,
    input  logic signed [IN_W-1:0]  i_x_value,
    input  logic signed [IN_W-1:0]  i_y_value,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    output logic signed [OUT_W-1:0] o_slope,
    output logic signed [OUT_W-1:0] o_intercept,
    output logic                    o_flagged
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int QW  = 2 * SAMPLE_BITS + CW;
    localparam int AW  = QW + SW + 1;
    localparam int NW  = AW + 16;
    localparam int DW  = AW + FRACTION_BITS;
    localparam int MCW = $clog2(SW + 1);
    localparam int DCW = $clog2(NW + 1);
    localparam logic signed [IN_W:0] S_HI = (IN_W+1)'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [IN_W:0] S_LO = ~S_HI;
    localparam logic [OUT_W+1:0] LIM_POS = (OUT_W+2)'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [OUT_W+1:0] LIM_NEG = (OUT_W+2)'(64'd1 << (OUT_W - 1));

    function automatic logic signed [IN_W-1:0] f_clamp(input logic signed [IN_W:0] v);
        if (v > S_HI) return S_HI[IN_W-1:0];
        if (v < S_LO) return S_LO[IN_W-1:0];
        return v[IN_W-1:0];
    endfunction

    function automatic logic f_over(input logic signed [IN_W:0] v);
        return (v > S_HI) || (v < S_LO);
    endfunction

    logic                    r_fit_mode, r_x_source;
    logic signed [IN_W-1:0]  r_x_start, r_x_step, r_gen_x;
    logic [CW-1:0]           r_count;
    logic signed [SW-1:0]    r_sx, r_sy;
    logic signed [QW-1:0]    r_sxx, r_sxy;
    logic                    r_ovf, r_sat;
    logic signed [OUT_W-1:0] r_slope, r_icpt;

    logic [AW-1:0]           r_ma;
    logic [SW-1:0]           r_mb;
    logic                    r_mneg, r_mbusy;
    logic [MCW-1:0]          r_mcnt;
    logic signed [AW-1:0]    r_acc, r_d;

    logic [NW-1:0]           r_num;
    logic [DW-1:0]           r_den, r_rem;
    logic [OUT_W:0]          r_q;
    logic                    r_qovf, r_dneg, r_dicpt, r_dbusy;
    logic [DCW-1:0]          r_dcnt;

    logic signed [IN_W:0]    x_ext, y_ext, g_ext, cfg_ext;
    logic signed [IN_W-1:0]  x_use, y_cl;
    logic                    in_flag, room;
    logic signed [2*IN_W-1:0] p_xx, p_xy;

    logic signed [QW-1:0]    a_val;
    logic signed [SW-1:0]    b_val;
    logic [QW-1:0]           a_mag;
    logic [SW-1:0]           b_mag;
    logic [AW-1:0]           m_term;

    logic signed [AW-1:0]    num_val, den_val;
    logic [AW-1:0]           num_mag, den_mag;
    logic [DW:0]             rs, rd;
    logic                    ge, rnd_up, q_sat;
    logic [OUT_W+1:0]        qr, lim;
    logic [OUT_W-1:0]        q_mag, q_res;

    assign x_ext   = {i_x_value[IN_W-1], i_x_value};
    assign y_ext   = {i_y_value[IN_W-1], i_y_value};
    assign g_ext   = {r_gen_x[IN_W-1], r_gen_x} + {r_x_step[IN_W-1], r_x_step};
    assign cfg_ext = {i_cfg_data[IN_W-1], i_cfg_data};
    assign x_use   = r_x_source ? f_clamp(x_ext) : r_gen_x;
    assign y_cl    = f_clamp(y_ext);
    assign in_flag = (r_x_source && f_over(x_ext)) || f_over(y_ext);
    assign room    = (r_count != CW'(MAX_SAMPLES));
    assign p_xx    = x_use * x_use;
    assign p_xy    = x_use * y_cl;

    always_comb begin
        case (i_cmd.asel)
            A_SXX:   a_val = r_sxx;
            A_SX:    a_val = QW'(r_sx);
            A_SXY:   a_val = r_sxy;
            default: a_val = '0;
        endcase
        case (i_cmd.bsel)
            B_N:     b_val = SW'($signed({1'b0, r_count}));
            B_SX:    b_val = r_sx;
            B_SY:    b_val = r_sy;
            default: b_val = '0;
        endcase
        case (i_cmd.nsel)
            N_ACC:   num_val = r_acc;
            N_SXY:   num_val = AW'(r_sxy);
            N_SY:    num_val = AW'(r_sy);
            default: num_val = '0;
        endcase
        case (i_cmd.dsel)
            D_REG:   den_val = r_d;
            D_SXX:   den_val = AW'(r_sxx);
            D_N:     den_val = AW'($signed({1'b0, r_count}));
            default: den_val = '0;
        endcase
    end

    assign a_mag   = a_val[QW-1] ? -a_val : a_val;
    assign b_mag   = b_val[SW-1] ? -b_val : b_val;
    assign num_mag = num_val[AW-1] ? -num_val : num_val;
    assign den_mag = den_val[AW-1] ? -den_val : den_val;
    assign m_term  = r_mneg ? -r_ma : r_ma;

    assign rs     = {r_rem, r_num[NW-1]};
    assign ge     = rs >= {1'b0, r_den};
    assign rd     = {r_rem, 1'b0};
    assign rnd_up = rd >= {1'b0, r_den};
    assign qr     = {1'b0, r_q} + (OUT_W+2)'(rnd_up);
    assign lim    = r_dneg ? LIM_NEG : LIM_POS;
    assign q_sat  = r_qovf || (qr > lim);
    assign q_mag  = q_sat ? lim[OUT_W-1:0] : qr[OUT_W-1:0];
    assign q_res  = r_dneg ? -q_mag : q_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= 1'b1;
            r_x_source <= 1'b0;
            r_x_start  <= '0;
            r_x_step   <= IN_W'(4096);
            r_gen_x    <= '0;
            r_count    <= '0;
            r_sx       <= '0;
            r_sy       <= '0;
            r_sxx      <= '0;
            r_sxy      <= '0;
            r_ovf      <= 1'b0;
            r_sat      <= 1'b0;
            r_mbusy    <= 1'b0;
            r_dbusy    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FIT_MODE: r_fit_mode <= i_cfg_data[0];
                    CFG_X_SOURCE: r_x_source <= i_cfg_data[0];
                    CFG_X_START: begin
                        r_x_start <= i_cfg_data;
                        if (r_count == '0) r_gen_x <= f_clamp(cfg_ext);
                    end
                    CFG_X_STEP:   r_x_step <= i_cfg_data;
                    default:      r_fit_mode <= r_fit_mode;
                endcase
            end

            if (i_accept) begin
                if (in_flag) r_ovf <= 1'b1;
                if (room) begin
                    r_count <= r_count + CW'(1);
                    r_sx    <= r_sx + SW'(x_use);
                    r_sy    <= r_sy + SW'(y_cl);
                    r_sxx   <= r_sxx + QW'(p_xx);
                    r_sxy   <= r_sxy + QW'(p_xy);
                    if (!r_x_source) begin
                        r_gen_x <= f_clamp(g_ext);
                        if (f_over(g_ext)) r_ovf <= 1'b1;
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            if (i_cmd.clr_res) begin
                r_slope <= '0;
                r_icpt  <= '0;
                r_sat   <= 1'b0;
            end

            if (i_cmd.store_d) r_d <= r_acc;

            if (i_cmd.mul_go) begin
                r_ma    <= AW'(a_mag);
                r_mb    <= b_mag;
                r_mneg  <= a_val[QW-1] ^ b_val[SW-1] ^ i_cmd.mul_sub;
                r_mcnt  <= MCW'(SW);
                r_mbusy <= 1'b1;
                if (i_cmd.mul_clr) r_acc <= '0;
            end else if (r_mbusy) begin
                if (r_mb[0]) r_acc <= r_acc + $signed(m_term);
                r_ma   <= r_ma << 1;
                r_mb   <= r_mb >> 1;
                r_mcnt <= r_mcnt - MCW'(1);
                if (r_mcnt == MCW'(1)) r_mbusy <= 1'b0;
            end

            if (i_cmd.div_go) begin
                r_num   <= {num_mag, 16'b0};
                r_den   <= i_cmd.div_shift ? (DW'(den_mag) << FRACTION_BITS) : DW'(den_mag);
                r_rem   <= '0;
                r_q     <= '0;
                r_qovf  <= 1'b0;
                r_dneg  <= num_val[AW-1] ^ den_val[AW-1];
                r_dicpt <= i_cmd.div_to_icpt;
                r_dcnt  <= DCW'(NW);
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (r_dcnt != '0) begin
                    r_rem  <= ge ? DW'(rs - {1'b0, r_den}) : rs[DW-1:0];
                    r_num  <= r_num << 1;
                    r_q    <= {r_q[OUT_W-1:0], ge};
                    r_qovf <= r_qovf | r_q[OUT_W];
                    r_dcnt <= r_dcnt - DCW'(1);
                end else begin
                    if (r_dicpt) r_icpt <= q_res;
                    else r_slope <= q_res;
                    if (q_sat) r_sat <= 1'b1;
                    r_dbusy <= 1'b0;
                end
            end

            if (i_cmd.emit) begin
                r_count <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sxx   <= '0;
                r_sxy   <= '0;
                r_ovf   <= 1'b0;
                r_gen_x <= f_clamp({r_x_start[IN_W-1], r_x_start});
            end
        end
    end

    assign o_status.fit_mode = r_fit_mode;
    assign o_status.sxx_zero = (r_sxx == '0);
    assign o_status.n_zero   = (r_count == '0);
    assign o_status.acc_zero = (r_acc == '0);
    assign o_status.mul_busy = r_mbusy;
    assign o_status.div_busy = r_dbusy;
    assign o_slope           = r_slope;
    assign o_intercept       = r_icpt;
    assign o_flagged         = r_ovf | r_sat;

endmodule

[rtl/least_squares_line_fit.sv]
// A sample without last is taken at once and the next may follow straight after it.
// A last sample holds busy for the solve, which is paced by the one-bit-per-cycle
// multiply-accumulate unit and the one-bit-per-cycle divider.
// The result strobe is high for one cycle; the receiver cannot stall.
// Synchronous active-low reset restores register defaults and empties the set.
// ----------------------------------------------------------------------------
// Least-squares line fit
// Accumulates samples and fits a line through the origin or with intercept.
// ----------------------------------------------------------------------------
module least_squares_line_fit
    import lslf_pkg::*;
#(
    parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int FRACTION_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [IN_W-1:0]         i_cfg_data,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [IN_W-1:0]  i_x_value,
    input  logic signed [IN_W-1:0]  i_y_value,
    input  logic                    i_last,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_slope,
    output logic signed [OUT_W-1:0] o_intercept,
    output logic [1:0]              o_rank,
    output logic                    o_flagged
);

    t_cmd    cmd;
    t_status status;
    logic    accept;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    lslf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_last),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_rank   (o_rank)
    );

    lslf_datapath #(
        .MAX_SAMPLES   (MAX_SAMPLES),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_slope     (o_slope),
        .o_intercept (o_intercept),
        .o_flagged   (o_flagged)
    );

`ifndef SYNTHESIS
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result beat outside a solve");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result beat longer than one cycle");
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rank != 2'd3)) else $error("rank out of range");
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> busy) else $error("last beat did not start a solve");
`endif

endmodule
